### design/plst_pkg.sv
`default_nettype none

package plst_pkg;

   typedef struct packed {
      logic [2:0]         func;
      logic [5:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic [5:0]         element_index;
      logic [5:0]         length;
      logic               last;
   } rsp_type;

   localparam logic [2:0] FN_INS_HEAD = 3'd0;
   localparam logic [2:0] FN_INS_TAIL = 3'd1;
   localparam logic [2:0] FN_INS_POS  = 3'd2;
   localparam logic [2:0] FN_DEL_HEAD = 3'd3;
   localparam logic [2:0] FN_DEL_TAIL = 3'd4;
   localparam logic [2:0] FN_DEL_POS  = 3'd5;
   localparam logic [2:0] FN_READ     = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef enum logic [1:0] {
      OP_INS  = 2'd0,
      OP_DEL  = 2'd1,
      OP_READ = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      AT_HEAD = 2'd0,
      AT_TAIL = 2'd1,
      AT_POS  = 2'd2
   } where_type;

   typedef struct packed {
      op_type             op;
      where_type          where;
      logic [5:0]         position;
      logic signed [31:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_READ = 2'b10
   } back_state_type;

endpackage

`default_nettype wire

### design/positional_list_store.sv
// channel   | ports                         | handshake
// ----------+-------------------------------+-------------------------------
// request   | start, busy, req_item         | taken when start && !busy
// response  | rsp_valid, rsp_item           | one-cycle strobe, never stalled
//
// edit and status-only items can follow back to back; each is written into the command
// queue, then taken by the back end, which registers its response.
// a non-empty read-out holds the back end while it takes the item and then gives one
// response per element; meanwhile the two-entry command queue can fill and raise busy.
// reset clears the element count, queue and sequencer; cell contents stay
// undefined until written.
`default_nettype none

module positional_list_store
   import plst_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   plst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   plst_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

### design/plst_front.sv
`default_nettype none

module plst_front
   import plst_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  wire logic    cmd_pop
);

   cmd_type    dec;
   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   // classify the item
   always_comb begin
      dec.position = req_item.position;
      dec.value    = req_item.value;
      dec.op       = OP_NOP;
      dec.where    = AT_HEAD;
      case (req_item.func)
         FN_INS_HEAD: begin
            dec.op    = OP_INS;
            dec.where = AT_HEAD;
         end
         FN_INS_TAIL: begin
            dec.op    = OP_INS;
            dec.where = AT_TAIL;
         end
         FN_INS_POS: begin
            dec.op    = OP_INS;
            dec.where = AT_POS;
         end
         FN_DEL_HEAD: begin
            dec.op    = OP_DEL;
            dec.where = AT_HEAD;
         end
         FN_DEL_TAIL: begin
            dec.op    = OP_DEL;
            dec.where = AT_TAIL;
         end
         FN_DEL_POS: begin
            dec.op    = OP_DEL;
            dec.where = AT_POS;
         end
         FN_READ: begin
            dec.op    = OP_READ;
         end
         default: begin
            dec.op    = OP_NOP;
         end
      endcase
   end

   assign busy      = (cnt_ff == 2'd2);
   assign push      = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

### design/plst_back.sv
`default_nettype none

module plst_back
   import plst_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int XW = ((CW > 6) ? CW : 6) + 1;

   back_state_type     state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic signed [31:0] cells_ff [DEPTH];
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               take;
   logic               full;
   logic [XW-1:0]      pos_x, cnt_x;
   logic [XW-1:0]      k_x;
   logic [IW-1:0]      k;
   logic [IW-1:0]      rd_addr;
   logic signed [31:0] rd_data;
   logic               do_ins, do_del;
   logic               read_last;

   assign take    = (state_ff == BK_IDLE) && cmd_valid;
   assign cmd_pop = take;
   assign full    = (count_ff == CW'(DEPTH));
   assign pos_x   = XW'(cmd.position);
   assign cnt_x   = XW'(count_ff);
   assign rd_addr = (state_ff == BK_READ) ? idx_ff : k;
   assign rd_data = cells_ff[rd_addr];
   assign read_last = ((XW'(idx_ff) + XW'(1)) == cnt_x);

   // 0-based target slot
   always_comb begin
      k_x = pos_x - XW'(1);
      case (cmd.where)
         AT_HEAD: k_x = '0;
         AT_TAIL: k_x = (cmd.op == OP_INS) ? cnt_x : cnt_x - XW'(1);
         default: k_x = pos_x - XW'(1);
      endcase
   end
   assign k = k_x[IW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      do_ins       = 1'b0;
      do_del       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (take) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = ST_OK;
               rsp_in.element       = '0;
               rsp_in.element_index = '0;
               rsp_in.length        = 6'(count_ff);
               rsp_in.last          = 1'b1;
               case (cmd.op)
                  OP_INS: begin
                     if (full) begin
                        rsp_in.status = ST_FULL;
                     end else if (cmd.where == AT_POS &&
                                  (pos_x == '0 || pos_x > cnt_x + XW'(1))) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        do_ins        = 1'b1;
                        count_in      = count_ff + CW'(1);
                        rsp_in.length = 6'(count_in);
                     end
                  end
                  OP_DEL: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else if (cmd.where == AT_POS &&
                                  (pos_x == '0 || pos_x > cnt_x)) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        do_del         = 1'b1;
                        count_in       = count_ff - CW'(1);
                        rsp_in.element = rd_data;
                        rsp_in.length  = 6'(count_in);
                     end
                  end
                  OP_READ: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        idx_in       = '0;
                        state_in     = BK_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_READ: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = ST_OK;
            rsp_in.element       = rd_data;
            rsp_in.element_index = 6'(XW'(idx_ff) + XW'(1));
            rsp_in.length        = 6'(count_ff);
            rsp_in.last          = read_last;
            idx_in               = idx_ff + IW'(1);
            if (read_last) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // all cells shift at once
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [31:0] up_src, dn_src, cell_in;
      if (g == 0) begin : g_first
         assign up_src = cells_ff[0];
      end else begin : g_up
         assign up_src = cells_ff[g-1];
      end
      if (g == DEPTH - 1) begin : g_end
         assign dn_src = cells_ff[g];
      end else begin : g_dn
         assign dn_src = cells_ff[g+1];
      end
      always_comb begin
         cell_in = cells_ff[g];
         if (do_ins) begin
            if (IW'(g) == k) begin
               cell_in = cmd.value;
            end else if (IW'(g) > k && CW'(g) <= count_ff) begin
               cell_in = up_src;
            end
         end else if (do_del) begin
            if (IW'(g) >= k) begin
               cell_in = dn_src;
            end
         end
      end
      always_ff @(posedge clock) begin
         cells_ff[g] <= cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

### bench/positional_list_store_tb.sv
module positional_list_store_tb;
   import plst_pkg::*;

   localparam int DEPTH = 32;
   localparam int ITEM_TARGET = 330;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int REQ_BITS = $bits(req_type);
   localparam logic [2:0] FN_SPARE = 3'd7;

   typedef enum int {
      FILL_UP,
      DRAIN_DOWN,
      CHURN
   } round_kind_type;

   typedef struct {
      bit      pinned;
      rsp_type reply;
   } item_pin_type;

   typedef struct {
      req_type      req;
      item_pin_type pin;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   logic signed [31:0] list_cells [DEPTH];
   int                 list_len = 0;
   rsp_type            list_replies [$];
   item_pin_type       item_pins [$];
   int                 mismatches = 0;
   int                 idle_cycles = 0;

   positional_list_store #(.DEPTH(DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // list behavior, one call per accepted item
   function automatic void apply_list_op(req_type it, ref rsp_type outs[$]);
      rsp_type r;
      int      p;
      r = '0;
      r.last = 1'b1;
      case (it.func)
         FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
            if (list_len >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (it.func == FN_INS_HEAD) p = 1;
               else if (it.func == FN_INS_TAIL) p = list_len + 1;
               else p = it.position;
               if (p < 1 || p > list_len + 1) begin
                  r.status = ST_RANGE;
               end else begin
                  for (int i = list_len; i >= p; i--) list_cells[i] = list_cells[i - 1];
                  list_cells[p - 1] = it.value;
                  list_len++;
                  r.status = ST_OK;
               end
            end
            r.length = 6'(list_len);
            outs.push_back(r);
         end
         FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (it.func == FN_DEL_HEAD) p = 1;
               else if (it.func == FN_DEL_TAIL) p = list_len;
               else p = it.position;
               if (p < 1 || p > list_len) begin
                  r.status = ST_RANGE;
               end else begin
                  r.element = list_cells[p - 1];
                  for (int i = p; i < list_len; i++) list_cells[i - 1] = list_cells[i];
                  list_len--;
                  r.status = ST_OK;
               end
            end
            r.length = 6'(list_len);
            outs.push_back(r);
         end
         FN_READ: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
               outs.push_back(r);
            end else begin
               for (int i = 0; i < list_len; i++) begin
                  r.status = ST_OK;
                  r.element = list_cells[i];
                  r.element_index = 6'(i + 1);
                  r.length = 6'(list_len);
                  r.last = (i + 1 == list_len);
                  outs.push_back(r);
               end
            end
         end
         default: begin
            r.status = ST_OK;
            r.length = 6'(list_len);
            outs.push_back(r);
         end
      endcase
   endfunction

   function automatic void report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t %s: expected st %0d el %0d idx %0d len %0d last %0d, ",
                  $realtime, what, want.status, want.element, want.element_index,
                  want.length, want.last,
                  "got st %0d el %0d idx %0d len %0d last %0d",
                  got.status, got.element, got.element_index, got.length, got.last);
   endfunction

   // check results, then predict the item taken at this edge
   always @(posedge clock) begin
      rsp_type      want;
      rsp_type      fresh [$];
      item_pin_type pin;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (list_replies.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_item);
            end else begin
               want = list_replies.pop_front();
               if (rsp_item.status !== want.status || rsp_item.element !== want.element ||
                   rsp_item.element_index !== want.element_index ||
                   rsp_item.length !== want.length || rsp_item.last !== want.last)
                  report_mismatch("result mismatch", want, rsp_item);
            end
         end
         if (start && busy === 1'b0) begin
            pin = (item_pins.size() != 0) ? item_pins.pop_front()
                                          : item_pin_type'{1'b0, '0};
            fresh.delete();
            apply_list_op(req_item, fresh);
            if (pin.pinned) list_replies.push_back(pin.reply);
            else foreach (fresh[i]) list_replies.push_back(fresh[i]);
         end
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && busy === 1'b0) || rsp_valid === 1'b1) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic plan_row_type row(logic [2:0] f, logic [5:0] p, logic signed [31:0] v,
                                        bit pin = 1'b0, logic [1:0] st = ST_OK,
                                        logic [5:0] len = '0);
      plan_row_type r;
      r.req = '{func: f, position: p, value: v};
      r.pin.pinned = pin;
      r.pin.reply = '{status: st, element: '0, element_index: '0, length: len, last: 1'b1};
      return r;
   endfunction

   function automatic int count_after(req_type it, int c);
      case (it.func)
         FN_INS_HEAD, FN_INS_TAIL: return (c < DEPTH) ? c + 1 : c;
         FN_INS_POS: return (c < DEPTH && it.position >= 1 && it.position <= c + 1) ? c + 1 : c;
         FN_DEL_HEAD, FN_DEL_TAIL: return (c > 0) ? c - 1 : c;
         FN_DEL_POS: return (c > 0 && it.position >= 1 && it.position <= c) ? c - 1 : c;
         default: return c;
      endcase
   endfunction

   function automatic req_type pick_item(round_kind_type kind, int c);
      req_type it;
      int      roll;
      int      ins_pct;
      it.value = $urandom;
      it.position = '0;
      roll = $urandom_range(0, 99);
      ins_pct = (kind == FILL_UP) ? 90 : (kind == DRAIN_DOWN) ? 10 : 50;
      if (roll < 6) begin
         it.func = 3'($urandom_range(0, 7));
         it.position = 6'($urandom_range(0, 63));
      end else if (roll < 14) begin
         it.func = FN_READ;
      end else if ($urandom_range(0, 99) < ins_pct) begin
         it.func = 3'($urandom_range(FN_INS_HEAD, FN_INS_POS));
         it.position = 6'($urandom_range(1, c + 1));
      end else begin
         it.func = 3'($urandom_range(FN_DEL_HEAD, FN_DEL_POS));
         it.position = (c == 0) ? 6'd1 : 6'($urandom_range(1, c));
      end
      return it;
   endfunction

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_item(req_type it, item_pin_type pin);
      item_pins.push_back(pin);
      req_item <= it;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic rest(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         req_item <= req_type'(REQ_BITS'({$urandom, $urandom}));
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (list_replies.size() != 0);
      @(posedge clock);
   endtask

   initial begin
      plan_row_type   directed_rows [$];
      round_kind_type kind;
      req_type        it;
      int             sent;
      int             fill_level;
      int             round_items;
      bit             steady;
      directed_rows = '{
         row(FN_READ,     0, 0, 1, ST_EMPTY, 0),
         row(FN_DEL_HEAD, 0, 0, 1, ST_EMPTY, 0),
         row(FN_DEL_TAIL, 0, 0, 1, ST_EMPTY, 0),
         row(FN_DEL_POS,  1, 0, 1, ST_EMPTY, 0),
         row(FN_DEL_POS,  0, 0, 1, ST_EMPTY, 0),
         row(FN_INS_POS,  0, 5, 1, ST_RANGE, 0),
         row(FN_INS_POS,  2, 5, 1, ST_RANGE, 0),
         row(FN_SPARE,    0, 0, 1, ST_OK, 0),
         row(FN_INS_HEAD, 0, 32'sh7fff_ffff, 1, ST_OK, 1),
         row(FN_INS_TAIL, 63, 32'sh8000_0000, 1, ST_OK, 2),
         row(FN_INS_POS,  2, -1, 1, ST_OK, 3),
         row(FN_INS_POS,  63, 7, 1, ST_RANGE, 3),
         row(FN_INS_POS,  4, 0, 1, ST_OK, 4),
         row(FN_INS_POS,  1, 32'sh5555_aaaa, 1, ST_OK, 5),
         row(FN_READ,     0, 0),
         row(FN_DEL_POS,  0, 0, 1, ST_RANGE, 5),
         row(FN_DEL_POS,  6, 0, 1, ST_RANGE, 5),
         row(FN_DEL_POS,  63, 0, 1, ST_RANGE, 5),
         row(FN_DEL_POS,  3, 0),
         row(FN_DEL_HEAD, 0, 0),
         row(FN_DEL_TAIL, 0, 0),
         row(FN_SPARE,    63, -1),
         row(FN_READ,     0, 0)
      };
      sent = 0;
      fill_level = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].req, directed_rows[i].pin);
         fill_level = count_after(directed_rows[i].req, fill_level);
         sent++;
      end
      wait_drained();

      // rounds biased toward filling, draining or churning the list
      kind = FILL_UP;
      round_items = 60;
      while (sent < ITEM_TARGET) begin
         steady = ($urandom_range(0, 99) < 30);
         for (int n = 0; n < round_items && sent < ITEM_TARGET; n++) begin
            it = pick_item(kind, fill_level);
            send_item(it, '{1'b0, '0});
            fill_level = count_after(it, fill_level);
            sent++;
            if (!steady) rest(gap_len());
         end
         if ($urandom_range(0, 99) < 30) wait_drained();
         kind = round_kind_type'($urandom_range(FILL_UP, CHURN));
         round_items = $urandom_range(25, 55);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && list_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
design/plst_pkg.sv
design/plst_front.sv
design/plst_back.sv
design/positional_list_store.sv
bench/positional_list_store_tb.sv
